// File: design/dllm_pkg.sv
// Shared types, codes and the microcode store of the doubly linked list manager.
// Depends on nothing; every other design file imports it.
package dllm_pkg;

	// Field widths of the input and result words.
	localparam int KIND_W = 3;
	localparam int NODE_W = 7;
	localparam int NEW_W = 6;
	localparam int RES_W = 6;

	// Default number of node slots; the root sentinel sits one above the last slot.
	localparam int NODE_SLOTS_DEF = 64;

	// Operation codes carried by the kind field.
	localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd0;
	localparam logic [KIND_W-1:0] KIND_APPEND = 3'd1;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd2;
	localparam logic [KIND_W-1:0] KIND_INSERT = 3'd3;
	localparam logic [KIND_W-1:0] KIND_UNLINK = 3'd4;
	localparam logic [KIND_W-1:0] KIND_FIRST = 3'd5;
	localparam logic [KIND_W-1:0] KIND_SUCC = 3'd6;

	// Operand sources for link memory addresses and write data.
	typedef enum logic [2:0] {
		SEL_ROOT = 3'd0,
		SEL_NODE = 3'd1,
		SEL_NEW = 3'd2,
		SEL_A = 3'd3,
		SEL_B = 3'd4,
		SEL_RDN = 3'd5,
		SEL_RDP = 3'd6
	} sel_t;

	// Load sources of the A scratch register.
	typedef enum logic [1:0] {
		A_NONE = 2'd0,
		A_NXT = 2'd1,
		A_PRV = 2'd2,
		A_PRV_OR_ROOT = 2'd3
	} a_src_t;

	// How a step produces the result of the operation.
	typedef enum logic [2:0] {
		RES_NONE = 3'd0,
		RES_A = 3'd1,
		RES_RDN = 3'd2,
		RES_RDN_NOT_ROOT = 3'd3,
		RES_B_NOT_ROOT = 3'd4
	} res_t;

	// Jump conditions.
	typedef enum logic [1:0] {
		COND_NONE = 2'd0,
		COND_EMPTY = 2'd1,
		COND_RD_EQ = 2'd2,
		COND_BOTH_ROOT = 2'd3
	} cond_t;

	// Microcode address width and entry points.
	localparam int UC_AW = 5;
	localparam logic [UC_AW-1:0] UA_NOP = 5'd0;
	localparam logic [UC_AW-1:0] UA_CLEAR = 5'd1;
	localparam logic [UC_AW-1:0] UA_APP0 = 5'd2;
	localparam logic [UC_AW-1:0] UA_APP1 = 5'd3;
	localparam logic [UC_AW-1:0] UA_APP2 = 5'd4;
	localparam logic [UC_AW-1:0] UA_APP3 = 5'd5;
	localparam logic [UC_AW-1:0] UA_INS0 = 5'd6;
	localparam logic [UC_AW-1:0] UA_INS1 = 5'd7;
	localparam logic [UC_AW-1:0] UA_INS2 = 5'd8;
	localparam logic [UC_AW-1:0] UA_RMH0 = 5'd9;
	localparam logic [UC_AW-1:0] UA_RMH1 = 5'd10;
	localparam logic [UC_AW-1:0] UA_RMH2 = 5'd11;
	localparam logic [UC_AW-1:0] UA_RMH3 = 5'd12;
	localparam logic [UC_AW-1:0] UA_UNL0 = 5'd13;
	localparam logic [UC_AW-1:0] UA_UNL1 = 5'd14;
	localparam logic [UC_AW-1:0] UA_UNL2 = 5'd15;
	localparam logic [UC_AW-1:0] UA_FST0 = 5'd16;
	localparam logic [UC_AW-1:0] UA_FST1 = 5'd17;
	localparam logic [UC_AW-1:0] UA_SUC0 = 5'd18;
	localparam logic [UC_AW-1:0] UA_SUC1 = 5'd19;

	// One control word of the microprogram.
	typedef struct packed {
		logic rd_nxt;
		sel_t rd_nxt_sel;
		logic rd_prv;
		sel_t rd_prv_sel;
		logic wr_nxt;
		sel_t wr_nxt_addr;
		sel_t wr_nxt_data;
		logic wr_prv;
		sel_t wr_prv_addr;
		sel_t wr_prv_data;
		a_src_t ld_a;
		logic ld_b;
		logic clr_flag;
		res_t res;
		cond_t cond;
		logic [UC_AW-1:0] target;
		logic last;
	} ctrl_t;

	// Status the datapath reports to the sequencer.
	typedef struct packed {
		logic flag;
		logic rd_eq;
		logic both_root;
		logic node_ok;
		logic node_root;
		logic node_real;
		logic new_ok;
	} stat_t;

	// Microprogram store. Reads issued in one step return data in the next.
	function automatic ctrl_t ucode(input logic [UC_AW-1:0] pc);
		ctrl_t c;
		c = '0;
		unique case (pc)
			// Clear only drops the nonempty flag.
			UA_CLEAR: begin
				c.clr_flag = 1'b1;
				c.last = 1'b1;
			end
			// Append NEW ahead of the root: p is the old tail, or the root when empty.
			UA_APP0: begin
				c.rd_prv = 1'b1;
				c.rd_prv_sel = SEL_ROOT;
			end
			UA_APP1: begin
				c.ld_a = A_PRV_OR_ROOT;
				c.wr_nxt = 1'b1;
				c.wr_nxt_addr = SEL_NEW;
				c.wr_nxt_data = SEL_ROOT;
			end
			UA_APP2: begin
				c.wr_prv = 1'b1;
				c.wr_prv_addr = SEL_NEW;
				c.wr_prv_data = SEL_A;
				c.wr_nxt = 1'b1;
				c.wr_nxt_addr = SEL_A;
				c.wr_nxt_data = SEL_NEW;
			end
			UA_APP3: begin
				c.wr_prv = 1'b1;
				c.wr_prv_addr = SEL_ROOT;
				c.wr_prv_data = SEL_NEW;
				c.last = 1'b1;
			end
			// Insert NEW ahead of NODE.
			UA_INS0: begin
				c.rd_prv = 1'b1;
				c.rd_prv_sel = SEL_NODE;
			end
			UA_INS1: begin
				c.wr_nxt = 1'b1;
				c.wr_nxt_addr = SEL_RDP;
				c.wr_nxt_data = SEL_NEW;
				c.wr_prv = 1'b1;
				c.wr_prv_addr = SEL_NEW;
				c.wr_prv_data = SEL_RDP;
			end
			UA_INS2: begin
				c.wr_nxt = 1'b1;
				c.wr_nxt_addr = SEL_NEW;
				c.wr_nxt_data = SEL_NODE;
				c.wr_prv = 1'b1;
				c.wr_prv_addr = SEL_NODE;
				c.wr_prv_data = SEL_NEW;
				c.last = 1'b1;
			end
			// Remove head: read both root links, give up when the list is empty.
			UA_RMH0: begin
				c.rd_nxt = 1'b1;
				c.rd_nxt_sel = SEL_ROOT;
				c.rd_prv = 1'b1;
				c.rd_prv_sel = SEL_ROOT;
				c.cond = COND_EMPTY;
				c.target = UA_NOP;
			end
			UA_RMH1: begin
				c.ld_a = A_NXT;
				c.rd_nxt = 1'b1;
				c.rd_nxt_sel = SEL_RDN;
				c.cond = COND_RD_EQ;
				c.target = UA_RMH3;
			end
			UA_RMH2: begin
				c.wr_nxt = 1'b1;
				c.wr_nxt_addr = SEL_ROOT;
				c.wr_nxt_data = SEL_RDN;
				c.wr_prv = 1'b1;
				c.wr_prv_addr = SEL_RDN;
				c.wr_prv_data = SEL_ROOT;
				c.res = RES_A;
				c.last = 1'b1;
			end
			// The head was the only node.
			UA_RMH3: begin
				c.clr_flag = 1'b1;
				c.res = RES_A;
				c.last = 1'b1;
			end
			// Unlink NODE; a node linked to the root on both sides goes through remove head.
			UA_UNL0: begin
				c.rd_nxt = 1'b1;
				c.rd_nxt_sel = SEL_NODE;
				c.rd_prv = 1'b1;
				c.rd_prv_sel = SEL_NODE;
			end
			UA_UNL1: begin
				c.ld_a = A_PRV;
				c.ld_b = 1'b1;
				c.cond = COND_BOTH_ROOT;
				c.target = UA_RMH0;
			end
			UA_UNL2: begin
				c.wr_nxt = 1'b1;
				c.wr_nxt_addr = SEL_A;
				c.wr_nxt_data = SEL_B;
				c.wr_prv = 1'b1;
				c.wr_prv_addr = SEL_B;
				c.wr_prv_data = SEL_A;
				c.res = RES_B_NOT_ROOT;
				c.last = 1'b1;
			end
			// First node.
			UA_FST0: begin
				c.rd_nxt = 1'b1;
				c.rd_nxt_sel = SEL_ROOT;
				c.cond = COND_EMPTY;
				c.target = UA_NOP;
			end
			UA_FST1: begin
				c.res = RES_RDN;
				c.last = 1'b1;
			end
			// Successor of NODE.
			UA_SUC0: begin
				c.rd_nxt = 1'b1;
				c.rd_nxt_sel = SEL_NODE;
			end
			UA_SUC1: begin
				c.res = RES_RDN_NOT_ROOT;
				c.last = 1'b1;
			end
			default: begin
				c.last = 1'b1;
			end
		endcase
		return c;
	endfunction

endpackage

// File: design/dllm_datapath.sv
// Datapath of the doubly linked list manager: link memories, scratch registers,
// nonempty flag and result register. Depends on dllm_pkg.
module dllm_datapath import dllm_pkg::*; #(
	parameter int NODE_SLOTS = NODE_SLOTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [KIND_W-1:0] kind,
	input logic [NODE_W-1:0] node,
	input logic [NEW_W-1:0] new_node,
	input ctrl_t ctrl,
	output stat_t stat,
	output logic res_found,
	output logic [RES_W-1:0] res_node
);

	localparam int LW = $clog2(NODE_SLOTS + 1);
	localparam logic [LW-1:0] ROOT = LW'(NODE_SLOTS);

	logic [LW-1:0] nxt_mem [0:NODE_SLOTS];
	logic [LW-1:0] prv_mem [0:NODE_SLOTS];
	logic [LW-1:0] rdn_q;
	logic [LW-1:0] rdp_q;
	logic [LW-1:0] nd_q;
	logic [LW-1:0] nn_q;
	logic [LW-1:0] a_q;
	logic [LW-1:0] b_q;
	logic [LW-1:0] res_q;
	logic found_q;
	logic quiet_q;
	logic flag_q;
	logic [LW-1:0] nxt_raddr;
	logic [LW-1:0] prv_raddr;
	logic [LW-1:0] nxt_waddr;
	logic [LW-1:0] nxt_wdata;
	logic [LW-1:0] prv_waddr;
	logic [LW-1:0] prv_wdata;

	function automatic logic [LW-1:0] pick(input sel_t s, input logic [LW-1:0] nd,
		input logic [LW-1:0] nn, input logic [LW-1:0] a, input logic [LW-1:0] b,
		input logic [LW-1:0] rdn, input logic [LW-1:0] rdp);
		logic [LW-1:0] v;
		unique case (s)
			SEL_NODE: v = nd;
			SEL_NEW: v = nn;
			SEL_A: v = a;
			SEL_B: v = b;
			SEL_RDN: v = rdn;
			SEL_RDP: v = rdp;
			default: v = ROOT;
		endcase
		return v;
	endfunction

	// Operand selection for the memory ports.
	always_comb begin
		nxt_raddr = pick(ctrl.rd_nxt_sel, nd_q, nn_q, a_q, b_q, rdn_q, rdp_q);
		prv_raddr = pick(ctrl.rd_prv_sel, nd_q, nn_q, a_q, b_q, rdn_q, rdp_q);
		nxt_waddr = pick(ctrl.wr_nxt_addr, nd_q, nn_q, a_q, b_q, rdn_q, rdp_q);
		nxt_wdata = pick(ctrl.wr_nxt_data, nd_q, nn_q, a_q, b_q, rdn_q, rdp_q);
		prv_waddr = pick(ctrl.wr_prv_addr, nd_q, nn_q, a_q, b_q, rdn_q, rdp_q);
		prv_wdata = pick(ctrl.wr_prv_data, nd_q, nn_q, a_q, b_q, rdn_q, rdp_q);
	end

	// Next link memory with a registered read port.
	always_ff @(posedge clk) begin
		if (ctrl.wr_nxt) begin
			nxt_mem[nxt_waddr] <= nxt_wdata;
		end
		if (ctrl.rd_nxt) begin
			rdn_q <= nxt_mem[nxt_raddr];
		end
	end

	// Previous link memory with a registered read port.
	always_ff @(posedge clk) begin
		if (ctrl.wr_prv) begin
			prv_mem[prv_waddr] <= prv_wdata;
		end
		if (ctrl.rd_prv) begin
			rdp_q <= prv_mem[prv_raddr];
		end
	end

	// Nonempty flag: any write of the root's next link marks the list nonempty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 1'b0;
		end else if (ctrl.clr_flag) begin
			flag_q <= 1'b0;
		end else if (ctrl.wr_nxt && nxt_waddr == ROOT) begin
			flag_q <= 1'b1;
		end
	end

	// Operand capture at accept and scratch registers during the program.
	always_ff @(posedge clk) begin
		if (start) begin
			// Append works as an insert ahead of the root.
			if (kind == KIND_APPEND) begin
				nd_q <= ROOT;
				nn_q <= LW'(node);
			end else begin
				nd_q <= LW'(node);
				nn_q <= LW'(new_node);
			end
			quiet_q <= (kind == KIND_UNLINK);
		end
		case (ctrl.ld_a)
			A_NXT: a_q <= rdn_q;
			A_PRV: a_q <= rdp_q;
			A_PRV_OR_ROOT: a_q <= flag_q ? rdp_q : ROOT;
			default: a_q <= a_q;
		endcase
		if (ctrl.ld_b) begin
			b_q <= rdn_q;
		end
	end

	// Result register; the value stays zero unless a node is found.
	always_ff @(posedge clk) begin
		if (start) begin
			found_q <= 1'b0;
			res_q <= '0;
		end else begin
			case (ctrl.res)
				// Remove head reached from unlink returns nothing.
				RES_A: begin
					if (!quiet_q) begin
						found_q <= 1'b1;
						res_q <= a_q;
					end
				end
				RES_RDN: begin
					found_q <= 1'b1;
					res_q <= rdn_q;
				end
				RES_RDN_NOT_ROOT: begin
					if (rdn_q != ROOT) begin
						found_q <= 1'b1;
						res_q <= rdn_q;
					end
				end
				RES_B_NOT_ROOT: begin
					if (b_q != ROOT) begin
						found_q <= 1'b1;
						res_q <= b_q;
					end
				end
				default: begin
					found_q <= found_q;
				end
			endcase
		end
	end

	// Status toward the sequencer; operand range checks look at the input word.
	always_comb begin
		stat.flag = flag_q;
		stat.rd_eq = (rdn_q == rdp_q);
		stat.both_root = (rdn_q == ROOT) && (rdp_q == ROOT);
		stat.node_ok = 32'(node) <= 32'(NODE_SLOTS);
		stat.node_root = 32'(node) == 32'(NODE_SLOTS);
		stat.node_real = 32'(node) < 32'(NODE_SLOTS);
		stat.new_ok = 32'(new_node) < 32'(NODE_SLOTS);
	end

	assign res_found = found_q;
	assign res_node = RES_W'(res_q);

endmodule

// File: design/dllm_seq.sv
// Microcode sequencer of the doubly linked list manager: dispatch, step counter
// and conditional jumps over the control store. Depends on dllm_pkg.
module dllm_seq import dllm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [KIND_W-1:0] kind,
	input stat_t stat,
	input logic out_free,
	output ctrl_t ctrl,
	output logic busy,
	output logic done
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN = 3'b010,
		ST_DONE = 3'b100
	} seq_st_t;

	seq_st_t state_q;
	logic [UC_AW-1:0] pc_q;
	logic [UC_AW-1:0] entry;
	ctrl_t word;
	logic jump;

	// Entry point of each operation; out-of-range operands run the empty program.
	always_comb begin
		unique case (kind)
			KIND_CLEAR: entry = UA_CLEAR;
			KIND_APPEND: entry = stat.node_real ? UA_APP0 : UA_NOP;
			KIND_REMOVE: entry = UA_RMH0;
			KIND_INSERT: begin
				if (stat.node_ok && stat.new_ok) begin
					entry = stat.node_root ? UA_APP0 : UA_INS0;
				end else begin
					entry = UA_NOP;
				end
			end
			KIND_UNLINK: entry = stat.node_real ? UA_UNL0 : UA_NOP;
			KIND_FIRST: entry = UA_FST0;
			KIND_SUCC: begin
				if (stat.node_ok && !(stat.node_root && !stat.flag)) begin
					entry = UA_SUC0;
				end else begin
					entry = UA_NOP;
				end
			end
			default: entry = UA_NOP;
		endcase
	end

	// Control word of the current step, quiet outside the program.
	always_comb begin
		word = ucode(pc_q);
		if (state_q == ST_RUN) begin
			ctrl = word;
		end else begin
			ctrl = '0;
		end
	end

	// Jump condition of the current step.
	always_comb begin
		unique case (word.cond)
			COND_EMPTY: jump = !stat.flag;
			COND_RD_EQ: jump = stat.rd_eq;
			COND_BOTH_ROOT: jump = stat.both_root;
			default: jump = 1'b0;
		endcase
	end

	// Step counter and run state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q <= UA_NOP;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_RUN;
						pc_q <= entry;
					end
				end
				ST_RUN: begin
					if (jump) begin
						pc_q <= word.target;
					end else if (word.last) begin
						state_q <= ST_DONE;
					end else begin
						pc_q <= pc_q + UC_AW'(1);
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

endmodule

// File: design/doubly_linked_list_manager.sv
// Top level of the doubly linked list manager: handshakes and the output word register.
// Depends on dllm_pkg, dllm_seq and dllm_datapath.
//
// The block keeps one circular doubly linked list over NODE_SLOTS node slots plus a root
// sentinel at slot NODE_SLOTS, and answers each input word with exactly one output word.
// It works on one operation at a time: a word enters when the block is idle, a microcode
// program of 1 to 5 steps runs on the next and previous link memories (each with one write
// and one registered read per cycle), and the answer then moves into the output register
// once that register is free. The block is idle again from the edge that loads the answer.
// The next operation may run while the previous answer still waits in the output register;
// its answer then waits until that word leaves. The link memories need no clearing pass
// after reset, and links of slots never written are undefined.
module doubly_linked_list_manager import dllm_pkg::*; #(
	parameter int NODE_SLOTS = NODE_SLOTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [KIND_W-1:0] kind,
	input logic [NODE_W-1:0] node,
	input logic [NEW_W-1:0] new_node,
	output logic out_valid,
	input logic out_ready,
	output logic found,
	output logic [RES_W-1:0] result_node
);

	ctrl_t ctrl;
	stat_t stat;
	logic busy;
	logic done;
	logic start;
	logic out_free;
	logic res_found;
	logic [RES_W-1:0] res_node;
	logic out_valid_q;
	logic found_q;
	logic [RES_W-1:0] result_node_q;

	// A word is taken whenever no operation is in flight.
	assign in_ready = !busy;
	assign start = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	dllm_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.kind(kind),
		.stat(stat),
		.out_free(out_free),
		.ctrl(ctrl),
		.busy(busy),
		.done(done)
	);

	dllm_datapath #(
		.NODE_SLOTS(NODE_SLOTS)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.kind(kind),
		.node(node),
		.new_node(new_node),
		.ctrl(ctrl),
		.stat(stat),
		.res_found(res_found),
		.res_node(res_node)
	);

	// Output word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done && out_free) begin
			found_q <= res_found;
			result_node_q <= res_node;
		end
	end

	assign out_valid = out_valid_q;
	assign found = found_q;
	assign result_node = result_node_q;

endmodule

// File: test/dllm_list_checker.sv
`timescale 1ns / 100ps
// Checker for the doubly linked list manager: it keeps its own copy of the link memories,
// predicts the answer to each accepted word and compares it with each returned word.
// Depends on dllm_pkg for field widths and operation codes.
module dllm_list_checker import dllm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic [KIND_W-1:0] kind,
	input logic [NODE_W-1:0] node,
	input logic [NEW_W-1:0] new_node,
	input logic out_valid,
	input logic out_ready,
	input logic found,
	input logic [RES_W-1:0] result_node,
	output int mismatches,
	output int answers_pending
);

	localparam logic [NODE_W-1:0] ROOT = NODE_W'(NODE_SLOTS_DEF);

	typedef struct packed {
		logic found;
		logic [RES_W-1:0] slot;
	} answer_t;

	// Predicted list state: links per slot, the root sentinel at the top slot.
	logic [NODE_W-1:0] next_of [0:NODE_SLOTS_DEF];
	logic [NODE_W-1:0] prev_of [0:NODE_SLOTS_DEF];
	logic populated;
	answer_t expected_answers[$];

	// Any write of the root's forward link marks the list as holding nodes.
	function automatic void write_next(input logic [NODE_W-1:0] slot,
			input logic [NODE_W-1:0] val);
		next_of[slot] = val;
		if (slot == ROOT) begin
			populated = 1'b1;
		end
	endfunction

	// Link a slot in at the tail, or make it the only node of an empty list.
	function automatic void append_slot(input logic [NODE_W-1:0] n);
		if (populated) begin
			prev_of[n] = prev_of[ROOT];
			write_next(n, ROOT);
			write_next(prev_of[ROOT], n);
			prev_of[ROOT] = n;
		end else begin
			prev_of[n] = ROOT;
			write_next(n, ROOT);
			prev_of[ROOT] = n;
			write_next(ROOT, n);
		end
	endfunction

	// Take the head off; a list whose root links agree held a single node.
	function automatic logic pop_head(output logic [NODE_W-1:0] head);
		head = '0;
		if (!populated) begin
			return 1'b0;
		end
		head = next_of[ROOT];
		if (prev_of[ROOT] != next_of[ROOT]) begin
			write_next(ROOT, next_of[head]);
			prev_of[next_of[head]] = ROOT;
		end else begin
			populated = 1'b0;
		end
		return 1'b1;
	endfunction

	// Apply one operation to the predicted state and return the answer it should give.
	function automatic answer_t apply_list_op(input logic [KIND_W-1:0] op,
			input logic [NODE_W-1:0] slot, input logic [NEW_W-1:0] fresh);
		logic [NODE_W-1:0] res;
		logic [NODE_W-1:0] added;
		logic hit;
		answer_t ans;
		res = '0;
		hit = 1'b0;
		added = {1'b0, fresh};
		case (op)
			KIND_CLEAR: begin
				populated = 1'b0;
			end
			KIND_APPEND: begin
				if (slot < ROOT) begin
					append_slot(slot);
				end
			end
			KIND_REMOVE: begin
				hit = pop_head(res);
			end
			KIND_INSERT: begin
				if (slot == ROOT) begin
					append_slot(added);
				end else if (slot < ROOT) begin
					write_next(prev_of[slot], added);
					prev_of[added] = prev_of[slot];
					write_next(added, slot);
					prev_of[slot] = added;
				end
			end
			KIND_UNLINK: begin
				// A node tied to the root on both sides leaves through the head path.
				if (slot < ROOT) begin
					if (prev_of[slot] != ROOT || next_of[slot] != ROOT) begin
						write_next(prev_of[slot], next_of[slot]);
						prev_of[next_of[slot]] = prev_of[slot];
						res = next_of[slot];
						hit = (res != ROOT);
					end else begin
						void'(pop_head(res));
					end
				end
			end
			KIND_FIRST: begin
				if (populated) begin
					hit = 1'b1;
					res = next_of[ROOT];
				end
			end
			KIND_SUCC: begin
				if (slot == ROOT) begin
					if (populated) begin
						res = next_of[ROOT];
						hit = (res != ROOT);
					end
				end else if (slot < ROOT) begin
					res = next_of[slot];
					hit = (res != ROOT);
				end
			end
			default: begin
			end
		endcase
		ans.found = hit;
		ans.slot = hit ? res[RES_W-1:0] : '0;
		return ans;
	endfunction

	// Compare returned words first: a word cannot answer the one accepted at the same edge.
	always @(posedge clk or negedge arst_n) begin : watch
		answer_t want;
		if (!arst_n) begin
			populated = 1'b0;
			expected_answers.delete();
			mismatches = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_answers.size() == 0) begin
					mismatches++;
					$display("%0t: word with no answer pending: found=%0b result_node=%0d",
						$time, found, result_node);
				end else begin
					want = expected_answers.pop_front();
					if (found !== want.found) begin
						mismatches++;
						$display("%0t: found expected %0b, got %0b",
							$time, want.found, found);
					end
					if (result_node !== want.slot) begin
						mismatches++;
						$display("%0t: result_node expected %0d, got %0d",
							$time, want.slot, result_node);
					end
				end
			end
			if (in_valid && in_ready) begin
				expected_answers.push_back(apply_list_op(kind, node, new_node));
			end
		end
		answers_pending = expected_answers.size();
	end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for the doubly linked list manager: clock, reset, stimulus and verdict.
// Depends on dllm_pkg, the block itself and dllm_list_checker.
module tb_top;
	import dllm_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;
	localparam logic [NODE_W-1:0] ROOT = NODE_W'(NODE_SLOTS_DEF);
	localparam int ITEM_TARGET = 1400;
	localparam int HOLD_CYCLES = 250;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [KIND_W-1:0] kind;
	logic [NODE_W-1:0] node;
	logic [NEW_W-1:0] new_node;
	logic out_valid;
	logic out_ready;
	logic found;
	logic [RES_W-1:0] result_node;
	int mismatches;
	int answers_pending;

	// Gap control shared by both sides, and requests for a long receiver hold.
	logic gaps_on;
	int hold_reqs;
	int words_sent;

	// Node order of the list as the stimulus means it; exact only between clears and noise.
	int members[$];
	bit in_list [NODE_SLOTS_DEF];

	doubly_linked_list_manager i_dut (.*);

	dllm_list_checker i_check (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit.
	initial begin
		#5ms;
		$display("FAILURE");
		$finish;
	end

	// Receiver: random stalls, plus a long hold each time one is requested.
	initial begin
		int hold_left;
		int holds_seen;
		hold_left = 0;
		holds_seen = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_reqs != holds_seen) begin
				holds_seen = hold_reqs;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= !(gaps_on && $urandom_range(99) < 29);
			end
		end
	end

	// Offer one word, with random gaps ahead of it, and wait until it is taken.
	task automatic send(input logic [KIND_W-1:0] k, input logic [NODE_W-1:0] n,
			input logic [NEW_W-1:0] nn);
		while (gaps_on && $urandom_range(99) < 29) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		node <= n;
		new_node <= nn;
		do @(posedge clk); while (!in_ready);
		if (k != KIND_UNUSED && n <= ROOT) begin
			words_sent++;
		end
	endtask

	// Stop offering until every answer has come back.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (answers_pending == 0);
	endtask

	function automatic int index_of(input int n);
		foreach (members[i]) begin
			if (members[i] == n) begin
				return i;
			end
		end
		return -1;
	endfunction

	// A random slot that is not in the list; callers make sure one exists.
	function automatic int free_slot();
		int n;
		n = $urandom_range(NODE_SLOTS_DEF - 1);
		while (in_list[n]) begin
			n = (n + 1) % NODE_SLOTS_DEF;
		end
		return n;
	endfunction

	function automatic int some_member();
		return members[$urandom_range(members.size() - 1)];
	endfunction

	// Well-formed operations; each keeps the stimulus view of the list in step.
	task automatic op_clear();
		send(KIND_CLEAR, NODE_W'($urandom), NEW_W'($urandom));
		members.delete();
		foreach (in_list[i]) begin
			in_list[i] = 1'b0;
		end
	endtask

	task automatic op_append(input int n);
		send(KIND_APPEND, NODE_W'(n), NEW_W'($urandom));
		members.push_back(n);
		in_list[n] = 1'b1;
	endtask

	task automatic op_insert(input int anchor, input int n);
		send(KIND_INSERT, NODE_W'(anchor), NEW_W'(n));
		if (anchor == ROOT) begin
			members.push_back(n);
		end else begin
			members.insert(index_of(anchor), n);
		end
		in_list[n] = 1'b1;
	endtask

	task automatic op_unlink(input int n);
		send(KIND_UNLINK, NODE_W'(n), NEW_W'($urandom));
		members.delete(index_of(n));
		in_list[n] = 1'b0;
	endtask

	task automatic op_remove();
		send(KIND_REMOVE, NODE_W'($urandom), NEW_W'($urandom));
		if (members.size() > 0) begin
			in_list[members[0]] = 1'b0;
			void'(members.pop_front());
		end
	endtask

	task automatic op_first();
		send(KIND_FIRST, NODE_W'($urandom), NEW_W'($urandom));
	endtask

	task automatic op_succ(input int n);
		send(KIND_SUCC, NODE_W'(n), NEW_W'($urandom));
	endtask

	// One random operation that keeps the list well formed; grow_pct biases toward growth.
	task automatic random_op(input int grow_pct);
		int pick;
		pick = $urandom_range(99);
		if (pick < grow_pct) begin
			if (members.size() == NODE_SLOTS_DEF) begin
				op_unlink(some_member());
			end else if ($urandom_range(1) == 0 || members.size() == 0) begin
				op_append(free_slot());
			end else if ($urandom_range(3) == 0) begin
				op_insert(ROOT, free_slot());
			end else begin
				op_insert(some_member(), free_slot());
			end
		end else begin
			pick = $urandom_range(99);
			if (pick < 25) begin
				op_remove();
			end else if (pick < 50) begin
				if (members.size() > 0) begin
					op_unlink(some_member());
				end else begin
					op_remove();
				end
			end else if (pick < 65) begin
				op_first();
			end else if (pick < 90) begin
				if (members.size() == 0 || $urandom_range(5) == 0) begin
					op_succ(ROOT);
				end else begin
					op_succ(some_member());
				end
			end else if ($urandom_range(1) == 0) begin
				send(KIND_UNUSED, NODE_W'($urandom), NEW_W'($urandom));
			end else begin
				// Slot above the root makes a node operation do nothing.
				case ($urandom_range(3))
					0: send(KIND_APPEND, NODE_W'($urandom_range(127, 65)), NEW_W'($urandom));
					1: send(KIND_INSERT, NODE_W'($urandom_range(127, 65)), NEW_W'($urandom));
					2: send(KIND_UNLINK, NODE_W'($urandom_range(127, 65)), NEW_W'($urandom));
					default: send(KIND_SUCC, NODE_W'($urandom_range(127, 65)), NEW_W'($urandom));
				endcase
			end
		end
	endtask

	// Anything at all: stale links, duplicate inserts, unlinks of free slots.
	task automatic noise_op();
		logic [NODE_W-1:0] n;
		if ($urandom_range(1) == 0) begin
			n = NODE_W'($urandom_range(127));
		end else begin
			n = NODE_W'($urandom_range(NODE_SLOTS_DEF));
		end
		send(KIND_W'($urandom_range(7)), n, NEW_W'($urandom));
	endtask

	initial begin
		int episode;
		int grow;
		int len;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		kind <= KIND_CLEAR;
		node <= '0;
		new_node <= '0;
		gaps_on <= 1'b1;
		hold_reqs <= 0;
		words_sent = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty list, links never written: only operations whose answers use no link.
		op_first();
		op_remove();
		op_succ(ROOT);
		send(KIND_UNUSED, 7'd127, 6'd63);
		send(KIND_APPEND, ROOT, 6'd0);
		send(KIND_APPEND, 7'd127, 6'd0);
		send(KIND_UNLINK, ROOT, 6'd0);
		send(KIND_UNLINK, 7'd100, 6'd0);
		send(KIND_INSERT, 7'd65, 6'd5);
		op_clear();

		// Fill every slot once so that every link is written from here on.
		for (int i = 0; i < NODE_SLOTS_DEF; i++) begin
			if (i % 2 == 0) begin
				op_append(free_slot());
			end else begin
				op_insert(ROOT, free_slot());
			end
		end

		// Full list, ends of the list, the only node and stale links.
		op_first();
		op_succ(ROOT);
		op_succ(members[members.size() - 1]);
		op_succ(members[0]);
		op_unlink(members[members.size() - 1]);
		op_unlink(members[0]);
		op_remove();
		op_insert(members[0], free_slot());
		op_insert(members[1], free_slot());
		op_clear();
		op_first();
		op_insert(ROOT, 63);
		op_unlink(63);
		op_first();
		op_append(0);
		op_remove();
		op_remove();
		op_succ(0);
		op_append(63);
		op_append(0);
		op_succ(63);
		op_unlink(63);
		send(KIND_UNLINK, ROOT, 6'd63);
		send(KIND_UNUSED, 7'd0, 6'd0);

		// Random episodes: clear, a well-formed run, sometimes a noisy tail.
		episode = 0;
		while (words_sent < ITEM_TARGET) begin
			gaps_on <= !(episode >= 18 && episode < 24);
			if (episode == 2 || episode == 11) begin
				hold_reqs <= hold_reqs + 1;
			end
			op_clear();
			if (episode % 9 == 4) begin
				grow = 92;
				len = 90;
			end else begin
				grow = $urandom_range(75, 35);
				len = $urandom_range(60, 8);
			end
			repeat (len) random_op(grow);
			if ($urandom_range(99) < 35) begin
				repeat ($urandom_range(6, 1)) noise_op();
			end
			if (episode == 5 || $urandom_range(99) < 12) begin
				drain();
			end
			episode++;
		end

		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && answers_pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// File: doubly_linked_list_manager.f
design/dllm_pkg.sv
design/dllm_datapath.sv
design/dllm_seq.sv
design/doubly_linked_list_manager.sv
test/dllm_list_checker.sv
test/tb_top.sv
